// File: rtl/rv32ieu_pkg.sv
// Shared types and codes for the RV32I execute unit.
package rv32ieu_pkg;

   localparam int unsigned XLEN       = 32;
   localparam int unsigned OP_W       = 6;
   localparam int unsigned RIDX_W     = 5;
   localparam int unsigned REQ_DATA_W = 88;
   localparam int unsigned RSP_DATA_W = 136;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 6'd0,  OP_SUB   = 6'd1,  OP_SLT   = 6'd2,  OP_SLTU  = 6'd3,
      OP_AND    = 6'd4,  OP_OR    = 6'd5,  OP_XOR   = 6'd6,  OP_SLL   = 6'd7,
      OP_SRL    = 6'd8,  OP_SRA   = 6'd9,  OP_ADDI  = 6'd10, OP_SLTI  = 6'd11,
      OP_SLTIU  = 6'd12, OP_ANDI  = 6'd13, OP_ORI   = 6'd14, OP_XORI  = 6'd15,
      OP_SLLI   = 6'd16, OP_SRLI  = 6'd17, OP_SRAI  = 6'd18, OP_BEQ   = 6'd19,
      OP_BGE    = 6'd20, OP_BGEU  = 6'd21, OP_BLT   = 6'd22, OP_BLTU  = 6'd23,
      OP_BNE    = 6'd24, OP_JAL   = 6'd25, OP_JALR  = 6'd26, OP_AUIPC = 6'd27,
      OP_LUI    = 6'd28, OP_LB    = 6'd29, OP_LBU   = 6'd30, OP_LH    = 6'd31,
      OP_LHU    = 6'd32, OP_LW    = 6'd33, OP_SB    = 6'd34, OP_SH    = 6'd35,
      OP_SW     = 6'd36, OP_HCF   = 6'd37, OP_UNIMPL = 6'd38
   } op_type;

   typedef enum logic [1:0] {
      MEM_NONE  = 2'd0,
      MEM_READ  = 2'd1,
      MEM_WRITE = 2'd2
   } mem_req_type;

   typedef enum logic [2:0] {
      ACC_LB  = 3'd0, ACC_LBU = 3'd1, ACC_LH = 3'd2, ACC_LHU = 3'd3,
      ACC_LW  = 3'd4, ACC_SB  = 3'd5, ACC_SH = 3'd6, ACC_SW  = 3'd7
   } access_kind_type;

   // Outcome of one executed instruction, handed from the execute logic to the top.
   typedef struct packed {
      logic            wr_en;
      logic [XLEN-1:0] wr_data;
      logic [XLEN-1:0] next_pc;
      logic            taken;
      mem_req_type     mem_req;
      logic [XLEN-1:0] mem_addr;
      logic [XLEN-1:0] store_data;
      access_kind_type kind;
      logic            halt;
      logic            unimpl;
   } ex_out_type;

endpackage

// File: rtl/rv32ieu_exec.sv
// Combinational execute logic: ALU, branch compare, jump and address generation.
module rv32ieu_exec (
   input  logic [rv32ieu_pkg::OP_W-1:0] op,
   input  logic [rv32ieu_pkg::XLEN-1:0] pc,
   input  logic [rv32ieu_pkg::XLEN-1:0] imm,
   input  logic [rv32ieu_pkg::XLEN-1:0] rb_val,
   input  logic [rv32ieu_pkg::XLEN-1:0] ry_val,
   output rv32ieu_pkg::ex_out_type      ex_out
);
   import rv32ieu_pkg::*;

   logic [XLEN-1:0] seq_pc;
   logic [XLEN-1:0] opnd_b;
   logic [XLEN-1:0] alu_res;
   logic [XLEN-1:0] base_sum;
   logic [4:0]      shamt;
   logic            lt_s;
   logic            lt_u;
   logic            br_lt_s;
   logic            br_lt_u;
   logic            br_eq;
   logic            is_reg_op;

   always_comb begin
      is_reg_op = (op <= OP_SRA);
      seq_pc    = pc + XLEN'(4);
      opnd_b    = is_reg_op ? ry_val : imm;
      shamt     = opnd_b[4:0];
      lt_u      = rb_val < opnd_b;
      lt_s      = (rb_val ^ 32'h8000_0000) < (opnd_b ^ 32'h8000_0000);
      base_sum  = rb_val + imm;
      // branches compare reg_a (port Y) against reg_b
      br_eq     = ry_val == rb_val;
      br_lt_u   = ry_val < rb_val;
      br_lt_s   = (ry_val ^ 32'h8000_0000) < (rb_val ^ 32'h8000_0000);

      case (op_type'(op))
         OP_ADD, OP_ADDI:   alu_res = rb_val + opnd_b;
         OP_SUB:            alu_res = rb_val - opnd_b;
         OP_SLT, OP_SLTI:   alu_res = {31'd0, lt_s};
         OP_SLTU, OP_SLTIU: alu_res = {31'd0, lt_u};
         OP_AND, OP_ANDI:   alu_res = rb_val & opnd_b;
         OP_OR, OP_ORI:     alu_res = rb_val | opnd_b;
         OP_XOR, OP_XORI:   alu_res = rb_val ^ opnd_b;
         OP_SLL, OP_SLLI:   alu_res = rb_val << shamt;
         OP_SRL, OP_SRLI:   alu_res = rb_val >> shamt;
         OP_SRA, OP_SRAI:   alu_res = XLEN'($signed(rb_val) >>> shamt);
         default:           alu_res = '0;
      endcase

      ex_out            = '0;
      ex_out.next_pc    = seq_pc;
      ex_out.mem_req    = MEM_NONE;
      ex_out.kind       = ACC_LB;

      case (op_type'(op))
         OP_ADD, OP_SUB, OP_SLT, OP_SLTU, OP_AND, OP_OR, OP_XOR, OP_SLL, OP_SRL,
         OP_SRA, OP_ADDI, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_SLLI,
         OP_SRLI, OP_SRAI: begin
            ex_out.wr_en   = 1'b1;
            ex_out.wr_data = alu_res;
         end
         OP_BEQ:  if (br_eq)    ex_out.next_pc = imm;
         OP_BNE:  if (!br_eq)   ex_out.next_pc = imm;
         OP_BLT:  if (br_lt_s)  ex_out.next_pc = imm;
         OP_BGE:  if (!br_lt_s) ex_out.next_pc = imm;
         OP_BLTU: if (br_lt_u)  ex_out.next_pc = imm;
         OP_BGEU: if (!br_lt_u) ex_out.next_pc = imm;
         OP_JAL: begin
            ex_out.wr_en   = 1'b1;
            ex_out.wr_data = seq_pc;
            ex_out.next_pc = imm;
         end
         OP_JALR: begin
            ex_out.wr_en   = 1'b1;
            ex_out.wr_data = seq_pc;
            ex_out.next_pc = {base_sum[XLEN-1:1], 1'b0};
         end
         OP_AUIPC: begin
            ex_out.wr_en   = 1'b1;
            ex_out.wr_data = pc + {imm[XLEN-13:0], 12'd0};
         end
         OP_LUI: begin
            ex_out.wr_en   = 1'b1;
            ex_out.wr_data = {imm[XLEN-13:0], 12'd0};
         end
         OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW: begin
            ex_out.mem_req  = MEM_READ;
            ex_out.mem_addr = base_sum;
            ex_out.kind     = access_kind_type'(3'(op - OP_LB));
         end
         OP_SB, OP_SH, OP_SW: begin
            ex_out.mem_req    = MEM_WRITE;
            ex_out.mem_addr   = base_sum;
            ex_out.store_data = ry_val;
            ex_out.kind       = access_kind_type'(3'(op - OP_LB));
         end
         OP_HCF:  ex_out.halt   = 1'b1;
         default: ex_out.unimpl = 1'b1;
      endcase

      ex_out.taken = ex_out.next_pc != seq_pc;
   end

endmodule

// File: rtl/rv32i_execute_unit_core.sv
// RV32I execute unit: register file memory, operand stage, execute and result register.
// An accepted beat is registered in the operand stage, and its result then in the rsp register.
// Throughput: one beat per cycle unless a held result register stalls the operand stage; the
// register file has two synchronous read ports and one write port, and forwards the last write.
// Write-back (req_tuser high) beats update the register file and give no result beat.
// Reset clears the program counter, all pipeline valids and the register-file valid
// bits at once, so every register reads as zero straight after reset.
module rv32i_execute_unit_core #(
   parameter int unsigned REG_COUNT = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // op[5:0], reg_a[10:6], reg_b[15:11], reg_c[20:16], imm[52:21],
   // load_data[84:53], zero pad[87:85]
   input  logic [rv32ieu_pkg::REQ_DATA_W-1:0]  req_tdata,
   // mode[0]: 0 execute, 1 load write-back
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // cur_pc[31:0], next_pc[63:32], branch_taken[64], mem_request[66:65],
   // mem_address[98:67], store_data[130:99], access_kind[133:131], halt[134],
   // unimplemented[135]
   output logic [rv32ieu_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import rv32ieu_pkg::*;

   localparam int unsigned RAW = $clog2(REG_COUNT);

   // input unpack
   logic [OP_W-1:0]   in_op;
   logic [RIDX_W-1:0] in_ra, in_rb, in_rc;
   logic [XLEN-1:0]   in_imm, in_ldata;
   logic [RAW-1:0]    rd_addr_b, rd_addr_y;
   logic              accept;

   // register file
   logic [XLEN-1:0]      rf_mem [REG_COUNT];
   logic [REG_COUNT-1:0] rf_valid_ff, rf_valid_in;
   logic [XLEN-1:0]      rdb_ff, rdy_ff;
   logic                 vb_ff, vy_ff;

   // operand stage
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_mode_ff;
   logic [OP_W-1:0]   s1_op_ff;
   logic [RAW-1:0]    s1_ra_ff, s1_rb_ff, s1_ry_ff;
   logic [XLEN-1:0]   s1_imm_ff, s1_ldata_ff;
   logic              s1_fire;
   logic              s1_exec;

   // last register-file write, forwarded over the read latency
   logic              wb_valid_ff, wb_valid_in;
   logic [RAW-1:0]    wb_addr_ff;
   logic [XLEN-1:0]   wb_data_ff;

   logic [XLEN-1:0]   pc_ff, pc_in;
   logic [XLEN-1:0]   rb_val, ry_val;
   ex_out_type        ex_out;
   logic              wr_en;
   logic [XLEN-1:0]   wr_data;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [XLEN-1:0]   rsp_cur_ff, rsp_next_ff, rsp_addr_ff, rsp_sdata_ff;
   logic              rsp_taken_ff, rsp_halt_ff, rsp_unimpl_ff;
   mem_req_type       rsp_req_ff;
   access_kind_type   rsp_kind_ff;

   assign in_op     = req_tdata[5:0];
   assign in_ra     = req_tdata[10:6];
   assign in_rb     = req_tdata[15:11];
   assign in_rc     = req_tdata[20:16];
   assign in_imm    = req_tdata[52:21];
   assign in_ldata  = req_tdata[84:53];
   assign rd_addr_b = in_rb[RAW-1:0];
   // register-register ops read reg_c on the second port, all others reg_a
   assign rd_addr_y = (in_op <= OP_SRA) ? in_rc[RAW-1:0] : in_ra[RAW-1:0];

   assign s1_exec    = s1_valid_ff && !s1_mode_ff;
   assign s1_fire    = s1_valid_ff && (s1_mode_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign accept     = req_tvalid && req_tready;

   // operands: forward the last write, else memory data masked by its valid bit
   always_comb begin
      if (wb_valid_ff && wb_addr_ff == s1_rb_ff) begin
         rb_val = wb_data_ff;
      end else begin
         rb_val = vb_ff ? rdb_ff : '0;
      end
      if (wb_valid_ff && wb_addr_ff == s1_ry_ff) begin
         ry_val = wb_data_ff;
      end else begin
         ry_val = vy_ff ? rdy_ff : '0;
      end
   end

   rv32ieu_exec u_exec (
      .op     (s1_op_ff),
      .pc     (pc_ff),
      .imm    (s1_imm_ff),
      .rb_val (rb_val),
      .ry_val (ry_val),
      .ex_out (ex_out)
   );

   always_comb begin
      wr_en        = s1_fire && (s1_mode_ff || ex_out.wr_en) && (s1_ra_ff != '0);
      wr_data      = s1_mode_ff ? s1_ldata_ff : ex_out.wr_data;
      rf_valid_in  = rf_valid_ff;
      if (wr_en) begin
         rf_valid_in[s1_ra_ff] = 1'b1;
      end
      wb_valid_in  = wb_valid_ff || wr_en;
      pc_in        = (s1_fire && s1_exec) ? ex_out.next_pc : pc_ff;
      s1_valid_in  = accept || (s1_valid_ff && !s1_fire);
      rsp_valid_in = (s1_fire && s1_exec) || (rsp_valid_ff && !rsp_tready);
   end

   // register file memory: two registered reads, one write
   always_ff @(posedge clock) begin
      if (accept) begin
         rdb_ff <= rf_mem[rd_addr_b];
         rdy_ff <= rf_mem[rd_addr_y];
      end
      if (wr_en) begin
         rf_mem[s1_ra_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff  <= '0;
         wb_valid_ff  <= 1'b0;
         pc_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rf_valid_ff  <= rf_valid_in;
         wb_valid_ff  <= wb_valid_in;
         pc_ff        <= pc_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff  <= req_tuser;
         s1_op_ff    <= in_op;
         s1_ra_ff    <= in_ra[RAW-1:0];
         s1_rb_ff    <= rd_addr_b;
         s1_ry_ff    <= rd_addr_y;
         s1_imm_ff   <= in_imm;
         s1_ldata_ff <= in_ldata;
         vb_ff       <= rf_valid_ff[rd_addr_b];
         vy_ff       <= rf_valid_ff[rd_addr_y];
      end
      if (wr_en) begin
         wb_addr_ff <= s1_ra_ff;
         wb_data_ff <= wr_data;
      end
      if (s1_fire && s1_exec) begin
         rsp_cur_ff    <= pc_ff;
         rsp_next_ff   <= ex_out.next_pc;
         rsp_taken_ff  <= ex_out.taken;
         rsp_req_ff    <= ex_out.mem_req;
         rsp_addr_ff   <= ex_out.mem_addr;
         rsp_sdata_ff  <= ex_out.store_data;
         rsp_kind_ff   <= ex_out.kind;
         rsp_halt_ff   <= ex_out.halt;
         rsp_unimpl_ff <= ex_out.unimpl;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_unimpl_ff, rsp_halt_ff, rsp_kind_ff, rsp_sdata_ff, rsp_addr_ff,
                        rsp_req_ff, rsp_taken_ff, rsp_next_ff, rsp_cur_ff};

   a_x0_never_valid: assert property (@(posedge clock) disable iff (reset)
      !rf_valid_ff[0])
      else $error("x0 marked as written");

   a_exec_gives_result: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_exec) |=> rsp_valid_ff)
      else $error("executed beat produced no result");

   a_pc_only_on_exec: assert property (@(posedge clock) disable iff (reset)
      !(s1_fire && s1_exec) |=> $stable(pc_ff))
      else $error("program counter moved without an executed beat");

   a_taken_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_taken_ff == (rsp_next_ff != (rsp_cur_ff + XLEN'(4)))))
      else $error("taken flag disagrees with next pc");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |=> s1_valid_ff)
      else $error("stalled operand stage dropped its beat");

endmodule

// File: test/rv32i_execute_unit_core_test.sv
// Self-checking testbench for the RV32I execute unit: directed and random instruction streams.
module rv32i_execute_unit_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rv32ieu_pkg::*;

   localparam int LONG_HOLD      = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int RANDOM_ITEMS   = 1100;
   localparam int CALM_TAIL      = 200;
   localparam logic [5:0] OP_UNKNOWN_TOP = 6'd63;
   localparam logic [5:0] OP_UNKNOWN_LOW = 6'd39;

   typedef struct packed {
      logic        mode;
      logic [5:0]  op;
      logic [4:0]  ra;
      logic [4:0]  rb;
      logic [4:0]  rc;
      logic [31:0] imm;
      logic [31:0] load_data;
   } instr_type;

   typedef struct packed {
      logic [31:0]     cur_pc;
      logic [31:0]     next_pc;
      logic            taken;
      mem_req_type     mem_req;
      logic [31:0]     mem_addr;
      logic [31:0]     store_data;
      access_kind_type kind;
      logic            halt;
      logic            unimpl;
   } outcome_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [31:0] gpr_model [32];
   logic [31:0] pc_model;
   outcome_type pending_outcomes [$];
   int          failures;
   int          stall_cycles;
   bit          sender_gaps;
   bit          receiver_gaps;
   bit          long_hold_req;

   rv32i_execute_unit_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] gpr_read(input logic [4:0] idx);
      return (idx == 5'd0) ? 32'd0 : gpr_model[idx];
   endfunction

   function automatic void gpr_write(input logic [4:0] idx, input logic [31:0] value);
      if (idx != 5'd0) gpr_model[idx] = value;
   endfunction

   function automatic logic [31:0] alu_result(input logic [5:0] op,
                                              input logic [31:0] a, input logic [31:0] b);
      logic [4:0] sh;
      sh = b[4:0];
      case (op)
         OP_ADD, OP_ADDI:   return a + b;
         OP_SUB:            return a - b;
         OP_SLT, OP_SLTI:   return {31'b0, $signed(a) < $signed(b)};
         OP_SLTU, OP_SLTIU: return {31'b0, a < b};
         OP_AND, OP_ANDI:   return a & b;
         OP_OR, OP_ORI:     return a | b;
         OP_XOR, OP_XORI:   return a ^ b;
         OP_SLL, OP_SLLI:   return a << sh;
         OP_SRL, OP_SRLI:   return a >> sh;
         OP_SRA, OP_SRAI:   return $signed(a) >>> sh;
         default:           return 32'd0;
      endcase
   endfunction

   // Execute one instruction against the model state and return what the block should emit.
   function automatic outcome_type execute_instr(input instr_type it);
      outcome_type o;
      logic [31:0] pc;
      logic [31:0] seq;
      logic [31:0] a;
      logic [31:0] b;
      logic [5:0]  kind_ofs;
      logic        take;
      pc   = pc_model;
      seq  = pc + 32'd4;
      a    = gpr_read(it.ra);
      b    = gpr_read(it.rb);
      take = 1'b0;
      o            = '0;
      o.cur_pc     = pc;
      o.next_pc    = seq;
      o.mem_req    = MEM_NONE;
      o.kind       = ACC_LB;
      kind_ofs     = it.op - OP_LB;
      case (it.op)
         OP_ADD, OP_SUB, OP_SLT, OP_SLTU, OP_AND, OP_OR, OP_XOR, OP_SLL, OP_SRL, OP_SRA:
            gpr_write(it.ra, alu_result(it.op, b, gpr_read(it.rc)));
         OP_ADDI, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_SLLI, OP_SRLI, OP_SRAI:
            gpr_write(it.ra, alu_result(it.op, b, it.imm));
         OP_BEQ:   take = (a == b);
         OP_BNE:   take = (a != b);
         OP_BGE:   take = !($signed(a) < $signed(b));
         OP_BLT:   take = $signed(a) < $signed(b);
         OP_BGEU:  take = (a >= b);
         OP_BLTU:  take = (a < b);
         OP_JAL: begin
            gpr_write(it.ra, seq);
            o.next_pc = it.imm;
         end
         OP_JALR: begin
            // target comes from the old base value, link is written afterwards
            o.next_pc = (b + it.imm) & ~32'd1;
            gpr_write(it.ra, seq);
         end
         OP_AUIPC: gpr_write(it.ra, pc + (it.imm << 12));
         OP_LUI:   gpr_write(it.ra, it.imm << 12);
         OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW: begin
            o.mem_req  = MEM_READ;
            o.mem_addr = b + it.imm;
            o.kind     = access_kind_type'(kind_ofs[2:0]);
         end
         OP_SB, OP_SH, OP_SW: begin
            o.mem_req    = MEM_WRITE;
            o.mem_addr   = b + it.imm;
            o.store_data = a;
            o.kind       = access_kind_type'(kind_ofs[2:0]);
         end
         OP_HCF:   o.halt = 1'b1;
         default:  o.unimpl = 1'b1;
      endcase
      if (take) o.next_pc = it.imm;
      o.taken  = (o.next_pc != seq);
      pc_model = o.next_pc;
      return o;
   endfunction

   function automatic void apply_beat(input instr_type it);
      if (it.mode) gpr_write(it.ra, it.load_data);
      else pending_outcomes.push_back(execute_instr(it));
   endfunction

   // ---------------------------------------------------------------- stimulus

   // Called and returns at a falling edge; tvalid is left high for a following beat.
   task automatic send_beat(input instr_type it);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.mode;
      req_tdata  <= {3'b000, it.load_data, it.imm, it.rc, it.rb, it.ra, it.op};
      do @(posedge clock); while (!req_tready);
      apply_beat(it);
      @(negedge clock);
   endtask

   task automatic issue(input logic [5:0] op, input logic [4:0] ra, input logic [4:0] rb,
                        input logic [4:0] rc, input logic [31:0] imm);
      instr_type it;
      it = '{mode: 1'b0, op: op, ra: ra, rb: rb, rc: rc, imm: imm, load_data: $urandom()};
      send_beat(it);
   endtask

   task automatic load_reply(input logic [4:0] ra, input logic [31:0] data);
      instr_type it;
      it = '{mode: 1'b1, op: 6'($urandom_range(0, 63)), ra: ra,
             rb: 5'($urandom_range(0, 31)), rc: 5'($urandom_range(0, 31)),
             imm: $urandom(), load_data: data};
      send_beat(it);
   endtask

   // Drop tvalid and hold until every outstanding result has been seen.
   task automatic wait_for_outcomes;
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_outcomes.size() != 0);
   endtask

   function automatic logic [4:0] pick_reg();
      // favour a few registers so that back-to-back dependencies are common
      if ($urandom_range(0, 1) == 0) return 5'($urandom_range(0, 3));
      return 5'($urandom_range(0, 31));
   endfunction

   function automatic logic [31:0] pick_imm();
      case ($urandom_range(0, 6))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'hFFFF_FFFF;
               default: return 32'd0;
            endcase
         end
         1: return 32'($urandom_range(0, 64));
         2: return -32'($urandom_range(1, 64));
         default: return $urandom();
      endcase
   endfunction

   function automatic instr_type random_instr();
      instr_type it;
      it.mode      = ($urandom_range(0, 7) == 0);
      it.op        = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(OP_UNKNOWN_LOW, 63))
                                                  : 6'($urandom_range(OP_ADD, OP_UNIMPL));
      it.ra        = pick_reg();
      it.rb        = pick_reg();
      it.rc        = pick_reg();
      it.imm       = pick_imm();
      it.load_data = ($urandom_range(0, 3) == 0) ? pick_imm() : $urandom();
      return it;
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_register_ops;
      load_reply(0, 32'hDEAD_BEEF);   // x0 stays zero
      load_reply(1, 32'hFFFF_FFFF);
      load_reply(2, 32'h8000_0000);
      load_reply(3, 32'h7FFF_FFFF);
      load_reply(4, 32'd33);          // shift by low five bits only
      issue(OP_ADD,  5, 1, 3, 0);
      issue(OP_SUB,  6, 2, 1, 0);
      issue(OP_SLT,  7, 2, 3, 0);
      issue(OP_SLTU, 8, 1, 3, 0);
      issue(OP_AND,  9, 1, 2, 0);
      issue(OP_OR,  10, 2, 3, 0);
      issue(OP_XOR, 11, 1, 3, 0);
      issue(OP_SLL, 12, 1, 4, 0);
      issue(OP_SRL, 13, 2, 4, 0);
      issue(OP_SRA, 14, 2, 4, 0);
      issue(OP_ADD,  0, 1, 1, 0);
      issue(OP_ADD, 15, 0, 3, 0);
      issue(OP_ADDI,  16, 3, 0, 32'd1);
      issue(OP_SLTI,  17, 2, 0, 32'hFFFF_FFFF);
      issue(OP_SLTIU, 18, 1, 0, 32'hFFFF_FFFF);
      issue(OP_ANDI,  19, 1, 0, 32'h8000_0000);
      issue(OP_ORI,   20, 0, 0, 32'hFFFF_FFFF);
      issue(OP_XORI,  21, 1, 0, 32'h7FFF_FFFF);
      issue(OP_SLLI,  22, 1, 0, 32'hFFFF_FFFF);
      issue(OP_SRLI,  23, 1, 0, 32'd32);
      issue(OP_SRAI,  24, 2, 0, 32'd31);
   endtask

   task automatic test_control_flow;
      issue(OP_BEQ,  0, 0, 0, pc_model + 32'd4);   // taken onto the fall-through address
      issue(OP_BEQ,  0, 0, 0, 32'hFFFF_FFFC);
      issue(OP_BNE,  1, 1, 0, 32'h0000_0100);
      issue(OP_BGE,  2, 3, 0, 32'h0000_0200);
      issue(OP_BGE,  3, 2, 0, 32'h0000_0300);
      issue(OP_BGEU, 2, 3, 0, 32'h0000_0400);
      issue(OP_BLT,  2, 3, 0, 32'h0000_0500);
      issue(OP_BLTU, 1, 0, 0, 32'h0000_0600);
      issue(OP_JAL, 25, 0, 0, 32'hFFFF_FFFF);
      issue(OP_JALR, 26, 1, 0, 32'd2);             // base plus offset wraps to one; clearing bit 0 gives target zero
      load_reply(27, 32'h0000_1001);
      issue(OP_JALR, 27, 27, 0, 32'h0000_0010);
      issue(OP_AUIPC, 28, 0, 0, 32'h000F_FFFF);
      issue(OP_LUI,   29, 0, 0, 32'hFFFF_FFFF);
   endtask

   task automatic test_memory_ops;
      issue(OP_LB,  30, 1, 0, 32'd1);
      issue(OP_LBU, 30, 2, 0, 32'hFFFF_FFFF);
      issue(OP_LH,  31, 3, 0, 32'd1);
      issue(OP_LHU, 31, 0, 0, 32'h8000_0000);
      issue(OP_LW,   0, 1, 0, 32'd0);
      load_reply(30, 32'hFFFF_FF80);
      load_reply(0,  32'h1234_5678);
      issue(OP_SB, 30, 1, 0, 32'd1);
      issue(OP_SH,  2, 3, 0, 32'd1);
      issue(OP_SW,  0, 2, 0, 32'hFFFF_FFFF);
      issue(OP_HCF, 5, 1, 2, 32'hFFFF_FFFF);
      issue(OP_ADD, 5, 3, 3, 0);
      issue(OP_UNIMPL, 6, 1, 1, 32'hFFFF_FFFF);
      issue(OP_UNKNOWN_TOP, 7, 1, 1, 32'hFFFF_FFFF);
   endtask

   task automatic test_receiver_backpressure;
      sender_gaps   = 1'b0;
      long_hold_req = 1'b1;
      repeat (40) send_beat(random_instr());
      wait_for_outcomes();
   endtask

   task automatic test_sender_pause;
      sender_gaps = 1'b1;
      repeat (12) send_beat(random_instr());
      wait_for_outcomes();
      repeat (12) send_beat(random_instr());
   endtask

   task automatic test_random_program(input int count);
      instr_type it;
      int        sent;
      int        next_switch;
      sent        = 0;
      next_switch = 0;
      while (sent < count) begin
         if (sent >= next_switch) begin
            // gaps on either side now and then, and none at all near the end
            sender_gaps   = (count - sent > CALM_TAIL) && ($urandom_range(0, 3) != 0);
            receiver_gaps = (count - sent > CALM_TAIL) && ($urandom_range(0, 3) != 0);
            next_switch   = sent + 100;
         end
         it = random_instr();
         send_beat(it);
         sent++;
         // answer most loads with their data, as a memory stage would
         if (!it.mode && it.op >= OP_LB && it.op <= OP_LW && $urandom_range(0, 3) != 0) begin
            load_reply(it.ra, $urandom());
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            $error("result beat with no instruction outstanding: %h", rsp_tdata);
            failures++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("cur_pc",        want.cur_pc,     rsp_tdata[31:0]);
            check_field("next_pc",       want.next_pc,    rsp_tdata[63:32]);
            check_field("branch_taken",  32'(want.taken), 32'(rsp_tdata[64]));
            check_field("mem_request",   32'(want.mem_req), 32'(rsp_tdata[66:65]));
            check_field("mem_address",   want.mem_addr,   rsp_tdata[98:67]);
            check_field("store_data",    want.store_data, rsp_tdata[130:99]);
            check_field("access_kind",   32'(want.kind),  32'(rsp_tdata[133:131]));
            check_field("halt",          32'(want.halt),  32'(rsp_tdata[134]));
            check_field("unimplemented", 32'(want.unimpl), 32'(rsp_tdata[135]));
         end
      end
   end

   // Count cycles in which work is waiting but no beat moves on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (!req_tvalid && pending_outcomes.size() == 0))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result receiver: random stalls, plus one long hold-off on request.
   initial begin
      @(negedge clock);
      forever begin
         if (long_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_req = 1'b0;
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      rsp_tready    = 1'b0;
      failures      = 0;
      stall_cycles  = 0;
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
      long_hold_req = 1'b0;
      pc_model      = 32'd0;
      foreach (gpr_model[i]) gpr_model[i] = 32'd0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_register_ops();
      test_control_flow();
      test_memory_ops();
      wait_for_outcomes();
      test_receiver_backpressure();
      test_sender_pause();
      test_random_program(RANDOM_ITEMS);

      wait_for_outcomes();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
